// ----- hw/rtl/per_cell_particle_moments_core_assert.svh -----
// Assertion macros shared by the per-cell particle moments RTL.
`ifndef PER_CELL_PARTICLE_MOMENTS_CORE_ASSERT_SVH
`define PER_CELL_PARTICLE_MOMENTS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clk_i edge, quiet while rst_ni is low.
`define PCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clk_i edge, reset included.
`define PCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PCM_ASSERT(lbl, prop, msg)
`define PCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/pcm_pkg.sv -----
// Shared widths, codes and types of the per-cell particle moments block.
`timescale 1ns / 1ps
package pcm_pkg;

  localparam int CELL_W    = 10;
  localparam int VEL_W     = 24;
  localparam int CNT_W     = 16;
  localparam int SUM_W     = 40;
  localparam int SQ_W      = 64;
  localparam int DENS_W    = 24;
  localparam int SPEED_W   = 24;
  localparam int TEMP_W    = 48;
  localparam int DSCALE_W  = 16;
  localparam int TSCALE_W  = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DENS_FRAC = 8;
  localparam int TEMP_FRAC = 16;
  localparam int MUL_W     = 24;
  localparam int ACC_W     = 128;
  localparam int OPB_W     = 64;
  localparam int NB_W      = 7;
  localparam int Q_W       = 80;
  localparam int ROOT_W    = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SCALE    = 1'b1;

  localparam logic [DSCALE_W-1:0] DSCALE_RST = 16'd256;
  localparam logic [TSCALE_W-1:0] TSCALE_RST = 32'd65536;
  localparam logic [TEMP_W-1:0]   TEMP_MAX   = '1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_SUB
  } eng_op_e;

  typedef struct packed {
    logic            start;
    eng_op_e         op;
    logic            clr_acc;
    logic [NB_W-1:0] nb;
  } eng_cmd_t;

  typedef struct packed {
    logic                    ovf;
    logic [SQ_W-1:0]         sq;
    logic signed [SUM_W-1:0] sz;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sx;
    logic [CNT_W-1:0]        cnt;
  } cell_rec_t;

endpackage

// ----- hw/rtl/per_cell_particle_moments_core.sv -----
// Per-cell particle velocity moments: accumulate particles, read out and clear cells.
// Add beat: square each axis into the record and write it back; a saturated count only
//   sets overflow and an out-of-range cell is dropped; the one 24x24 multiplier squares
//   one axis per cycle. Readout beat: bit-serial engine steps (three 40-bit squares, a
//   40-step root, a 40-step divide, two multiplies, a subtract, a 112-step divide).
// Empty cells skip the engine. Reset: a clearing pass writes every cell, input stalled.
`timescale 1ns / 1ps
`include "per_cell_particle_moments_core_assert.svh"
module per_cell_particle_moments_core #(
  parameter int NUM_CELLS   = 1024,
  parameter int VEL_WIDTH   = 24,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcm_pkg::CFG_W-1:0]     cfg_wdata_i,
  // command beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [pcm_pkg::CELL_W-1:0]    cell_req_i,
  input  logic signed [pcm_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [pcm_pkg::VEL_W-1:0] vel_y_i,
  input  logic signed [pcm_pkg::VEL_W-1:0] vel_z_i,
  // readout beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcm_pkg::CELL_W-1:0]    out_cell_o,
  output logic                          empty_res_o,
  output logic                          overflow_o,
  output logic [pcm_pkg::CNT_W-1:0]     particle_count_o,
  output logic [pcm_pkg::DENS_W-1:0]    density_o,
  output logic [pcm_pkg::SPEED_W-1:0]   mean_speed_o,
  output logic [pcm_pkg::TEMP_W-1:0]    temperature_o
);
  import pcm_pkg::*;

  localparam int AW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int REC_W = $bits(cell_rec_t);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'((1 << COUNT_WIDTH) - 1);
  localparam logic [AW-1:0]    LAST_CELL = AW'(NUM_CELLS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_SQ,
    ST_ADD_WR,
    ST_RO_RD,
    ST_RO_CLR,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_MEAN,
    ST_NSQ,
    ST_NUM,
    ST_SCALE,
    ST_TDIV,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic                 pend_q;
  logic [AW-1:0]        clr_cnt_q;
  logic [CELL_W-1:0]    cell_q;
  logic                 in_range_q;
  logic [VEL_W-1:0]     vel_x_q, vel_y_q, vel_z_q;
  logic [1:0]           axis_q;
  cell_rec_t            rec_q;
  logic [Q_W-1:0]       q_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SPEED_W-1:0]   mean_q;
  logic [DENS_W-1:0]    dens_q;
  logic [2*CNT_W-1:0]   nn_q;
  logic [TEMP_W-1:0]    temp_q;
  logic [DSCALE_W-1:0]  dscale_q;
  logic [TSCALE_W-1:0]  tscale_q;

  logic                 out_valid_q;
  logic [CELL_W-1:0]    out_cell_q;
  logic                 out_empty_q;
  logic                 out_ovf_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic [DENS_W-1:0]    out_dens_q;
  logic [SPEED_W-1:0]   out_speed_q;
  logic [TEMP_W-1:0]    out_temp_q;

  // Configuration registers: write only while idle; the block does not check this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dscale_q <= DSCALE_RST;
      tscale_q <= TSCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DENSITY_SCALE: dscale_q <= cfg_wdata_i[DSCALE_W-1:0];
        CFG_TEMP_SCALE:    tscale_q <= cfg_wdata_i[TSCALE_W-1:0];
        default:           dscale_q <= dscale_q;
      endcase
    end
  end

  // Input handshake: a new beat is taken only from the idle state, while a
  // finished readout may still sit in the output register.
  logic in_acc;
  logic in_range_now;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign in_range_now = (32'(cell_req_i) < NUM_CELLS);

  // Velocities: take the low VEL_WIDTH bits as a signed value.
  logic signed [VEL_WIDTH-1:0] vx_s, vy_s, vz_s, vsel;
  logic [VEL_WIDTH-1:0]        vsel_u, vmag;
  assign vx_s = vel_x_q[VEL_WIDTH-1:0];
  assign vy_s = vel_y_q[VEL_WIDTH-1:0];
  assign vz_s = vel_z_q[VEL_WIDTH-1:0];

  always_comb begin
    case (axis_q)
      2'd0:    vsel = vx_s;
      2'd1:    vsel = vy_s;
      default: vsel = vz_s;
    endcase
    vsel_u = vsel;
    vmag   = vsel_u[VEL_WIDTH-1] ? (~vsel_u + VEL_WIDTH'(1)) : vsel_u;
  end

  function automatic logic [SUM_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] u;
    u = s;
    return u[SUM_W-1] ? (~u + SUM_W'(1)) : u;
  endfunction

  // The one small multiplier: axis squares on adds, n*n and n*scale on readouts.
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  always_comb begin
    case (state_q)
      ST_ADD_SQ: begin
        mul_a = MUL_W'(vmag);
        mul_b = MUL_W'(vmag);
      end
      ST_RO_CLR: begin
        mul_a = MUL_W'(rec_q.cnt);
        mul_b = MUL_W'(rec_q.cnt);
      end
      default: begin
        mul_a = MUL_W'(rec_q.cnt);
        mul_b = MUL_W'(dscale_q);
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Cell record memory and its write mux.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [REC_W-1:0] mem_wdata;
  logic [REC_W-1:0] mem_rdata;
  cell_rec_t        rd_rec;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cell_q);
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rec_q;
      end
      ST_RO_CLR: begin
        mem_we    = in_range_q;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  pcm_store #(
    .DEPTH (NUM_CELLS),
    .WIDTH (REC_W),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (AW'(cell_req_i)),
    .rdata_o (mem_rdata)
  );

  assign rd_rec = cell_rec_t'(mem_rdata);

  // Updated record of an add: fold the particle in, or flag a saturated cell.
  cell_rec_t add_rec;
  always_comb begin
    add_rec = rd_rec;
    if (rd_rec.cnt >= CNT_MAX) begin
      add_rec.ovf = 1'b1;
    end else begin
      add_rec.cnt = rd_rec.cnt + CNT_W'(1);
      add_rec.sx  = rd_rec.sx + SUM_W'(vx_s);
      add_rec.sy  = rd_rec.sy + SUM_W'(vy_s);
      add_rec.sz  = rd_rec.sz + SUM_W'(vz_s);
    end
  end

  // Shared serial engine and the command for each readout step.
  eng_cmd_t         eng_cmd;
  logic [ACC_W-1:0] eng_a;
  logic [OPB_W-1:0] eng_b;
  logic [ACC_W-1:0] eng_acc, eng_opa;
  logic [OPB_W-1:0] eng_opb;
  logic             eng_busy;
  logic             step_done;

  assign step_done = pend_q && !eng_busy;

  always_comb begin
    eng_cmd.start   = 1'b0;
    eng_cmd.op      = OP_MUL;
    eng_cmd.clr_acc = 1'b0;
    eng_cmd.nb      = '0;
    eng_a           = '0;
    eng_b           = '0;
    case (state_q)
      ST_SQ_X: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.clr_acc = 1'b1;
        eng_cmd.nb      = NB_W'(SUM_W);
        eng_a           = ACC_W'(sum_mag(rec_q.sx));
        eng_b           = OPB_W'(sum_mag(rec_q.sx));
      end
      ST_SQ_Y: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.nb      = NB_W'(SUM_W);
        eng_a           = ACC_W'(sum_mag(rec_q.sy));
        eng_b           = OPB_W'(sum_mag(rec_q.sy));
      end
      ST_SQ_Z: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.nb      = NB_W'(SUM_W);
        eng_a           = ACC_W'(sum_mag(rec_q.sz));
        eng_b           = OPB_W'(sum_mag(rec_q.sz));
      end
      ST_SQRT: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.op      = OP_SQRT;
        eng_cmd.nb      = NB_W'(ROOT_W);
        eng_a           = {q_q, {(ACC_W-Q_W){1'b0}}};
      end
      ST_MEAN: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.op      = OP_DIV;
        eng_cmd.nb      = NB_W'(ROOT_W);
        eng_a           = {root_q, {(ACC_W-ROOT_W){1'b0}}};
        eng_b           = OPB_W'(rec_q.cnt);
      end
      ST_NSQ: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.clr_acc = 1'b1;
        eng_cmd.nb      = NB_W'(CNT_W);
        eng_a           = ACC_W'(rec_q.sq);
        eng_b           = OPB_W'(rec_q.cnt);
      end
      ST_NUM: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.op      = OP_SUB;
        eng_cmd.nb      = NB_W'(1);
        eng_a           = ACC_W'(q_q);
      end
      ST_SCALE: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.clr_acc = 1'b1;
        eng_cmd.nb      = NB_W'(TSCALE_W);
        eng_a           = eng_acc;
        eng_b           = OPB_W'(tscale_q);
      end
      ST_TDIV: begin
        eng_cmd.start   = !pend_q;
        eng_cmd.op      = OP_DIV;
        eng_cmd.nb      = NB_W'(ACC_W - TEMP_FRAC);
        eng_a           = {eng_acc[ACC_W-TEMP_FRAC-1:0], {TEMP_FRAC{1'b0}}};
        eng_b           = OPB_W'({nn_q, {TEMP_FRAC{1'b0}}});
      end
      default: begin
        eng_cmd.start   = 1'b0;
      end
    endcase
  end

  pcm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (eng_cmd),
    .a_i    (eng_a),
    .b_i    (eng_b),
    .acc_o  (eng_acc),
    .opa_o  (eng_opa),
    .opb_o  (eng_opb),
    .busy_o (eng_busy)
  );

  // Sequencer: one beat at a time; each readout step issues the engine once
  // (pend_q low), then waits for it to go idle (pend_q high).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pend_q      <= 1'b0;
      clr_cnt_q   <= '0;
      cell_q      <= '0;
      in_range_q  <= 1'b0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      vel_z_q     <= '0;
      axis_q      <= '0;
      rec_q       <= '0;
      q_q         <= '0;
      root_q      <= '0;
      mean_q      <= '0;
      dens_q      <= '0;
      nn_q        <= '0;
      temp_q      <= '0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_cnt_q   <= '0;
      out_dens_q  <= '0;
      out_speed_q <= '0;
      out_temp_q  <= '0;
    end else begin
      // drop the output beat once taken; ST_DONE reloads it in the same cycle
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cell_q     <= cell_req_i;
            in_range_q <= in_range_now;
            vel_x_q    <= vel_x_i;
            vel_y_q    <= vel_y_i;
            vel_z_q    <= vel_z_i;
            if (cmd_i) begin
              state_q <= ST_RO_RD;
            end else if (in_range_now) begin
              state_q <= ST_ADD_RD;
            end
          end
        end
        ST_ADD_RD: begin
          rec_q  <= add_rec;
          axis_q <= '0;
          if (rd_rec.cnt >= CNT_MAX) begin
            // saturated: drop the particle, flag the cell
            state_q <= ST_ADD_WR;
          end else begin
            state_q <= ST_ADD_SQ;
          end
        end
        ST_ADD_SQ: begin
          rec_q.sq <= rec_q.sq + SQ_W'(prod);
          axis_q   <= axis_q + 2'd1;
          if (axis_q == 2'd2) begin
            state_q <= ST_ADD_WR;
          end
        end
        ST_ADD_WR: begin
          state_q <= ST_IDLE;
        end
        ST_RO_RD: begin
          rec_q   <= in_range_q ? rd_rec : '0;
          state_q <= ST_RO_CLR;
        end
        ST_RO_CLR: begin
          nn_q    <= prod[2*CNT_W-1:0];
          state_q <= (rec_q.cnt == '0) ? ST_DONE : ST_SQ_X;
        end
        ST_SQ_X: begin
          if (!pend_q) begin
            dens_q <= prod[DENS_FRAC +: DENS_W];
            pend_q <= 1'b1;
          end else if (step_done) begin
            pend_q  <= 1'b0;
            state_q <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            pend_q  <= 1'b0;
            state_q <= ST_SQ_Z;
          end
        end
        ST_SQ_Z: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            q_q     <= eng_acc[Q_W-1:0];
            pend_q  <= 1'b0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            root_q  <= eng_opb[ROOT_W-1:0];
            pend_q  <= 1'b0;
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            mean_q  <= eng_opa[SPEED_W-1:0];
            pend_q  <= 1'b0;
            state_q <= ST_NSQ;
          end
        end
        ST_NSQ: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            pend_q  <= 1'b0;
            state_q <= ST_NUM;
          end
        end
        ST_NUM: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            pend_q  <= 1'b0;
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            pend_q  <= 1'b0;
            state_q <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (step_done) begin
            // saturate the quotient to the temperature width
            temp_q  <= (|eng_opa[ACC_W-TEMP_FRAC-1:TEMP_W]) ? TEMP_MAX
                                                            : eng_opa[TEMP_W-1:0];
            pend_q  <= 1'b0;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= cell_q;
            out_ovf_q   <= rec_q.ovf;
            out_cnt_q   <= rec_q.cnt;
            if (rec_q.cnt == '0) begin
              out_empty_q <= 1'b1;
              out_dens_q  <= '0;
              out_speed_q <= '0;
              out_temp_q  <= '0;
            end else begin
              out_empty_q <= 1'b0;
              out_dens_q  <= dens_q;
              out_speed_q <= mean_q;
              out_temp_q  <= temp_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_cell_o       = out_cell_q;
  assign empty_res_o      = out_empty_q;
  assign overflow_o       = out_ovf_q;
  assign particle_count_o = out_cnt_q;
  assign density_o        = out_dens_q;
  assign mean_speed_o     = out_speed_q;
  assign temperature_o    = out_temp_q;

  `PCM_ASSERT_ALWAYS(a_clear_stalls, (state_q == ST_CLEAR) |-> in_stall_o, "input while clearing")
  `PCM_ASSERT(a_engine_idle_on_accept, in_acc |-> !eng_busy, "beat taken while engine busy")
  `PCM_ASSERT(a_ro_clears, (mem_we && state_q == ST_RO_CLR) |-> (mem_wdata == '0), "bad clear")

endmodule

// ----- hw/rtl/pcm_store.sv -----
// Single-port-write, registered-read memory holding the per-cell records.
`timescale 1ns / 1ps
module pcm_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pcm_engine.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, square root, subtract.
`timescale 1ns / 1ps
`include "per_cell_particle_moments_core_assert.svh"
module pcm_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcm_pkg::eng_cmd_t         cmd_i,
  input  logic [pcm_pkg::ACC_W-1:0] a_i,
  input  logic [pcm_pkg::OPB_W-1:0] b_i,
  output logic [pcm_pkg::ACC_W-1:0] acc_o,
  output logic [pcm_pkg::ACC_W-1:0] opa_o,
  output logic [pcm_pkg::OPB_W-1:0] opb_o,
  output logic                      busy_o
);
  import pcm_pkg::*;

  eng_op_e         op_q;
  logic            busy_q;
  logic [NB_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q, opa_q;
  logic [OPB_W-1:0] opb_q;

  logic [ACC_W-1:0] x, y;
  logic             sub;
  logic [ACC_W:0]   sum;
  logic             carry;

  // One adder serves every operation; for subtraction carry means x >= y.
  always_comb begin
    case (op_q)
      OP_MUL: begin
        x = acc_q; y = opa_q; sub = 1'b0;
      end
      OP_DIV: begin
        x = {acc_q[ACC_W-2:0], opa_q[ACC_W-1]}; y = ACC_W'(opb_q); sub = 1'b1;
      end
      OP_SQRT: begin
        x = {acc_q[ACC_W-3:0], opa_q[ACC_W-1 -: 2]}; y = ACC_W'({opb_q, 2'b01});
        sub = 1'b1;
      end
      OP_SUB: begin
        x = acc_q; y = opa_q; sub = 1'b1;
      end
      default: begin
        x = acc_q; y = opa_q; sub = 1'b0;
      end
    endcase
    sum   = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (ACC_W+1)'(sub);
    carry = sum[ACC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_MUL;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.nb;
    end else if (busy_q) begin
      cnt_q <= cnt_q - NB_W'(1);
      if (cnt_q == NB_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opa_q <= a_i;
      opb_q <= b_i;
      if (cmd_i.clr_acc || cmd_i.op == OP_DIV || cmd_i.op == OP_SQRT) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (opb_q[0]) begin
            acc_q <= sum[ACC_W-1:0];
          end
          opa_q <= {opa_q[ACC_W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[OPB_W-1:1]};
        end
        OP_DIV: begin
          acc_q <= carry ? sum[ACC_W-1:0] : x;
          opa_q <= {opa_q[ACC_W-2:0], carry};
        end
        OP_SQRT: begin
          acc_q <= carry ? sum[ACC_W-1:0] : x;
          opa_q <= {opa_q[ACC_W-3:0], 2'b00};
          opb_q <= {opb_q[OPB_W-2:0], carry};
        end
        OP_SUB: begin
          acc_q <= sum[ACC_W-1:0];
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign acc_o  = acc_q;
  assign opa_o  = opa_q;
  assign opb_o  = opb_q;
  assign busy_o = busy_q;

  `PCM_ASSERT(a_no_start_busy, cmd_i.start |-> !busy_q, "engine started while busy")
  `PCM_ASSERT(a_busy_has_count, busy_q |-> (cnt_q != '0), "engine busy with no steps left")
  `PCM_ASSERT(a_last_step_ends, (busy_q && !cmd_i.start && cnt_q == NB_W'(1)) |=> !busy_q, "engine overran its step count")

endmodule
